/* rtl/ptt_pkg.sv */
// ptt_pkg: shared types and constants of the periodic timer table
// operation codes, table entry layout and the result transaction struct
package ptt_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_RMS  = 2'd2,
    OP_RMH  = 2'd3
  } op_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] interval;
    logic [31:0] handler;
  } ent_t;

  typedef struct packed {
    logic        vld;
    logic [4:0]  slot;
    logic        fired;
    logic        success;
    logic [31:0] handler;
    logic        last;
  } res_t;

endpackage

/* rtl/ptt_ram.sv */
// ptt_ram: generic single write, single read RAM with registered read data
// no dependencies
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ptt_ctrl.sv */
// ptt_ctrl: sequencer of the timer table, slot active flags and scan pipeline
// depends on ptt_pkg; drives the entry RAM read, modify and write back
module ptt_ctrl #(
  parameter int SLOTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [1:0]               operation,
  input  logic [31:0]              handler_id,
  input  logic [31:0]              interval_ticks,
  input  logic [4:0]               slot_index,
  output logic                     busy,
  output ptt_pkg::res_t            res,
  output logic [$clog2(SLOTS)-1:0] ram_raddr,
  input  logic [95:0]              ram_rdata,
  output logic                     ram_we,
  output logic [$clog2(SLOTS)-1:0] ram_waddr,
  output logic [95:0]              ram_wdata
);
  import ptt_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int XW = ((IW > 5) ? IW : 5) + 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN
  } state_t;

  state_t            st;
  op_t               op_r;
  logic [SLOTS-1:0]  active;
  logic [IW-1:0]     idx;
  logic              iss;
  logic              p_vld;
  logic [IW-1:0]     p_idx;
  logic [31:0]       hreg;
  logic [31:0]       ireg;
  logic              pend_vld;
  logic [IW-1:0]     pend_slot;
  logic [31:0]       pend_hnd;
  logic [NRES_W-1:0] nres;

  ent_t        ent;
  ent_t        wr_ent;
  logic [31:0] inc;
  logic        fire;
  logic        p_act;
  logic        take;
  logic        hit;
  logic        scan_end;
  logic        free_add;
  logic        add_end;
  logic        accept;
  logic [XW-1:0] rm_ix;
  logic        rms_ok;

  always_comb begin
    ent      = ent_t'(ram_rdata);
    inc      = (&ent.count) ? ent.count : ent.count + 32'd1;
    fire     = inc >= ent.interval;
    p_act    = active[p_idx];
    take     = (st == S_SCAN) && (op_r == OP_TICK) && p_vld && p_act && fire
               && (nres < NRES_W'(MAX_RESULTS));
    hit      = (st == S_SCAN) && (op_r == OP_RMH) && p_vld && p_act
               && (ent.handler == hreg);
    scan_end = (st == S_SCAN) && !iss && !p_vld;
    free_add = (st == S_ADD) && !active[idx];
    add_end  = (st == S_ADD) && (idx == LAST);
    accept   = start && (st == S_IDLE);
    rm_ix    = XW'(slot_index);
    rms_ok   = (rm_ix < XW'(SLOTS)) && active[rm_ix[IW-1:0]];
  end

  assign busy      = (st != S_IDLE);
  assign ram_raddr = idx;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = p_idx;
    wr_ent    = ent;
    if (free_add) begin
      ram_we          = 1'b1;
      ram_waddr       = idx;
      wr_ent.count    = '0;
      wr_ent.interval = ireg;
      wr_ent.handler  = hreg;
    end else if ((st == S_SCAN) && (op_r == OP_TICK) && p_vld && p_act) begin
      ram_we       = 1'b1;
      wr_ent.count = fire ? 32'd0 : inc;
    end
    ram_wdata = wr_ent;
  end

  always_comb begin
    res = '0;
    if (accept && (op_t'(operation) == OP_RMS)) begin
      res.vld     = 1'b1;
      res.slot    = slot_index;
      res.success = rms_ok;
      res.last    = 1'b1;
    end else if (free_add) begin
      res.vld     = 1'b1;
      res.slot    = 5'(idx);
      res.success = 1'b1;
      res.last    = 1'b1;
    end else if (add_end) begin
      res.vld  = 1'b1;
      res.last = 1'b1;
    end else if (take && pend_vld) begin
      res.vld     = 1'b1;
      res.slot    = 5'(pend_slot);
      res.fired   = 1'b1;
      res.handler = pend_hnd;
    end else if (hit) begin
      res.vld     = 1'b1;
      res.slot    = 5'(p_idx);
      res.success = 1'b1;
      res.last    = 1'b1;
    end else if (scan_end) begin
      res.vld  = 1'b1;
      res.last = 1'b1;
      if ((op_r == OP_TICK) && pend_vld) begin
        res.slot    = 5'(pend_slot);
        res.fired   = 1'b1;
        res.handler = pend_hnd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      active   <= '0;
      iss      <= 1'b0;
      p_vld    <= 1'b0;
      pend_vld <= 1'b0;
      nres     <= '0;
      op_r     <= OP_TICK;
      idx      <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            op_r     <= op_t'(operation);
            hreg     <= handler_id;
            ireg     <= interval_ticks;
            idx      <= '0;
            p_vld    <= 1'b0;
            pend_vld <= 1'b0;
            nres     <= '0;
            unique case (op_t'(operation))
              OP_TICK, OP_RMH: begin
                st  <= S_SCAN;
                iss <= 1'b1;
              end
              OP_ADD: begin
                st <= S_ADD;
              end
              OP_RMS: begin
                if (rms_ok) begin
                  active[rm_ix[IW-1:0]] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADD: begin
          if (free_add) begin
            active[idx] <= 1'b1;
            st          <= S_IDLE;
          end else if (add_end) begin
            st <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          p_vld <= iss;
          p_idx <= idx;
          if (iss) begin
            if ((idx == LAST) || hit) begin
              iss <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (take) begin
            pend_vld  <= 1'b1;
            pend_slot <= p_idx;
            pend_hnd  <= ent.handler;
            nres      <= nres + 1'b1;
          end
          if (hit) begin
            active[p_idx] <= 1'b0;
            st            <= S_IDLE;
          end
          if (scan_end) begin
            st <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/periodic_timer_table.sv */
// periodic_timer_table: top level, elapsed tick counter and result registers
// remove by slot is answered from the idle state without a scan; add, tick and remove by handler walk the entry RAM
// throughput: one transaction at a time, set by the one-entry-per-cycle RAM scan
// results are strobed for one cycle each and cannot be stalled by the receiver
// synchronous reset clears all slots, the tick counter and the sequencer at once
module periodic_timer_table #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] handler_id,
  input  logic [31:0] interval_ticks,
  input  logic [4:0]  slot_index,
  output logic        valid,
  output logic [4:0]  slot,
  output logic        fired,
  output logic        success,
  output logic [31:0] fired_handler,
  output logic [47:0] elapsed_ticks,
  output logic        last
);
  import ptt_pkg::*;

  localparam int IW = $clog2(SLOTS);

  res_t          res;
  logic [IW-1:0] ram_raddr;
  logic [95:0]   ram_rdata;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [95:0]   ram_wdata;
  logic [47:0]   tick_total;

  ptt_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .operation      (operation),
    .handler_id     (handler_id),
    .interval_ticks (interval_ticks),
    .slot_index     (slot_index),
    .busy           (busy),
    .res            (res),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  ptt_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total <= '0;
      valid      <= 1'b0;
    end else begin
      if (start && !busy && (op_t'(operation) == OP_TICK)) begin
        tick_total <= tick_total + 48'd1;
      end
      valid <= res.vld;
    end
    slot          <= res.slot;
    fired         <= res.fired;
    success       <= res.success;
    fired_handler <= res.handler;
    last          <= res.last;
  end

  assign elapsed_ticks = tick_total;

`ifndef SYNTHESIS
  a_rms_one: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op_t'(operation) == OP_RMS) |=> valid && last)
    else $error("remove by slot must give one final result next cycle");

  a_fire_no_success: assert property (@(posedge clk) disable iff (rst)
    valid && fired |-> !success)
    else $error("fired result with success set");

  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result while sequencer idle");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(tick_total))
    else $error("tick counter moved during a transaction");
`endif

endmodule
